/* rtl/grid_exit_path_count_dp_defines.svh */
// Assertion macros for the grid exit path counter.
// Depends on clk and rst_n being visible in the module that uses them.
`ifndef GRID_EXIT_PATH_COUNT_DP_DEFINES_SVH
`define GRID_EXIT_PATH_COUNT_DP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define GEPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define GEPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/gepc_pkg.sv */
// Package for the grid exit path counter: sizes, modulus, state type and
// the modular add helper. No dependencies.
`default_nettype none

package gepc_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int MAX_MOVES = 64;

  localparam int DIM_W   = 7;
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int DATA_W  = 30;
  localparam int ADDR_W  = 1 + ROW_W + COL_W;
  localparam int DEPTH   = 2 * (2 ** ROW_W) * (2 ** COL_W);

  localparam logic [DATA_W:0] MOD_P = 31'd1000000007;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SWEEP,
    ST_DRAIN,
    ST_READ,
    ST_WAIT,
    ST_OUT
  } state_t;

  function automatic logic [DATA_W-1:0] mod_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= MOD_P) begin
      s = s - MOD_P;
    end
    return s[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/grid_exit_path_count_dp.sv */
// Top level of the grid exit path counter: control sequencer, ping-pong
// layer memory and modular accumulator. Depends on gepc_pkg and the defines header.
`default_nettype none
`include "grid_exit_path_count_dp_defines.svh"

// One item gives a grid size, a move budget and a start cell; one result
// item returns the number of exiting move sequences modulo 1000000007.
// Sizes above 64 saturate to 64. A start cell outside the grid answers 1
// without a sweep. Otherwise the block clears layer 0, then computes each
// layer from the one before it and reads the answer from the last layer.
// Each cell needs four neighbor reads through the layer memory's two read
// ports, two per cycle. One item is worked on at a time; a new item is
// taken once the result has been taken.
module grid_exit_path_count_dp (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  [gepc_pkg::DIM_W-1:0]    in_grid_rows,
  input  wire  [gepc_pkg::DIM_W-1:0]    in_grid_cols,
  input  wire  [gepc_pkg::DIM_W-1:0]    in_move_budget,
  input  wire  [gepc_pkg::ROW_W-1:0]    in_start_row,
  input  wire  [gepc_pkg::COL_W-1:0]    in_start_col,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [gepc_pkg::DATA_W-1:0]   out_path_count
);
  import gepc_pkg::*;

  state_t              state_r, state_nxt;
  logic [DIM_W-1:0]    rows_r, rows_nxt;
  logic [DIM_W-1:0]    cols_r, cols_nxt;
  logic [DIM_W-1:0]    moves_r, moves_nxt;
  logic [ROW_W-1:0]    sr_r, sr_nxt;
  logic [COL_W-1:0]    sc_r, sc_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [DIM_W-1:0]    layer_r, layer_nxt;
  logic                cur_r, cur_nxt;
  logic                phase_r, phase_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   count_r, count_nxt;

  logic                s1_valid_r, s1_valid_nxt;
  logic                s1_phase_r, s1_phase_nxt;
  logic                s1_oob_a_r, s1_oob_a_nxt;
  logic                s1_oob_b_r, s1_oob_b_nxt;
  logic [ADDR_W-1:0]   s1_waddr_r, s1_waddr_nxt;
  logic [DATA_W-1:0]   acc_r, acc_nxt;

  logic [DATA_W-1:0]   layer_mem [DEPTH];
  logic [ADDR_W-1:0]   rd_a_addr, rd_b_addr;
  logic [DATA_W-1:0]   rd_a_data_r, rd_b_data_r;
  logic                clr_we;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [DATA_W-1:0]   wr_data;

  logic [DIM_W-1:0]    rows_sat, cols_sat, moves_sat;
  logic                last_col, last_row;
  logic [DATA_W-1:0]   val_a, val_b, sum_first;

  assign rows_sat  = (in_grid_rows > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : in_grid_rows;
  assign cols_sat  = (in_grid_cols > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : in_grid_cols;
  assign moves_sat = (in_move_budget > DIM_W'(MAX_MOVES)) ? DIM_W'(MAX_MOVES)
                                                          : in_move_budget;

  assign last_col = (({1'b0, col_r} + DIM_W'(1)) == cols_r);
  assign last_row = (({1'b0, row_r} + DIM_W'(1)) == rows_r);

  always_comb begin
    state_nxt     = state_r;
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    moves_nxt     = moves_r;
    sr_nxt        = sr_r;
    sc_nxt        = sc_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    layer_nxt     = layer_r;
    cur_nxt       = cur_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    count_nxt     = count_r;
    s1_valid_nxt  = 1'b0;
    s1_phase_nxt  = s1_phase_r;
    s1_oob_a_nxt  = s1_oob_a_r;
    s1_oob_b_nxt  = s1_oob_b_r;
    s1_waddr_nxt  = s1_waddr_r;
    rd_a_addr     = {cur_r, sr_r, sc_r};
    rd_b_addr     = {cur_r, sr_r, sc_r};
    clr_we        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          rows_nxt  = rows_sat;
          cols_nxt  = cols_sat;
          moves_nxt = moves_sat;
          sr_nxt    = in_start_row;
          sc_nxt    = in_start_col;
          if (({1'b0, in_start_row} >= rows_sat) || ({1'b0, in_start_col} >= cols_sat)) begin
            count_nxt     = DATA_W'(1);
            out_valid_nxt = 1'b1;
            state_nxt     = ST_OUT;
          end else begin
            row_nxt   = '0;
            col_nxt   = '0;
            cur_nxt   = 1'b0;
            phase_nxt = 1'b0;
            layer_nxt = DIM_W'(1);
            state_nxt = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        clr_we = 1'b1;
        if (last_col) begin
          col_nxt = '0;
          if (last_row) begin
            row_nxt   = '0;
            state_nxt = (moves_r == '0) ? ST_READ : ST_SWEEP;
          end else begin
            row_nxt = row_r + ROW_W'(1);
          end
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
      ST_SWEEP: begin
        s1_valid_nxt = 1'b1;
        s1_phase_nxt = phase_r;
        if (!phase_r) begin
          rd_a_addr    = {cur_r, row_r - ROW_W'(1), col_r};
          rd_b_addr    = {cur_r, row_r + ROW_W'(1), col_r};
          s1_oob_a_nxt = (row_r == '0);
          s1_oob_b_nxt = last_row;
          phase_nxt    = 1'b1;
        end else begin
          rd_a_addr    = {cur_r, row_r, col_r - COL_W'(1)};
          rd_b_addr    = {cur_r, row_r, col_r + COL_W'(1)};
          s1_oob_a_nxt = (col_r == '0);
          s1_oob_b_nxt = last_col;
          s1_waddr_nxt = {~cur_r, row_r, col_r};
          phase_nxt    = 1'b0;
          if (last_col) begin
            col_nxt = '0;
            if (last_row) begin
              row_nxt   = '0;
              state_nxt = ST_DRAIN;
            end else begin
              row_nxt = row_r + ROW_W'(1);
            end
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (!s1_valid_r) begin
          cur_nxt = ~cur_r;
          if (layer_r == moves_r) begin
            state_nxt = ST_READ;
          end else begin
            layer_nxt = layer_r + DIM_W'(1);
            state_nxt = ST_SWEEP;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        count_nxt     = rd_a_data_r;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Neighbor values arrive in the cycle after the reads; outside cells count one.
  assign val_a     = s1_oob_a_r ? DATA_W'(1) : rd_a_data_r;
  assign val_b     = s1_oob_b_r ? DATA_W'(1) : rd_b_data_r;
  assign sum_first = mod_add(s1_phase_r ? acc_r : val_a, s1_phase_r ? val_a : DATA_W'(0));
  assign acc_nxt   = mod_add(sum_first, val_b);

  assign wr_en   = clr_we || (s1_valid_r && s1_phase_r);
  assign wr_addr = clr_we ? {1'b0, row_r, col_r} : s1_waddr_r;
  assign wr_data = clr_we ? '0 : acc_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      layer_mem[wr_addr] <= wr_data;
    end
    rd_a_data_r <= layer_mem[rd_a_addr];
    rd_b_data_r <= layer_mem[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      layer_r     <= '0;
      cur_r       <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      s1_valid_r  <= s1_valid_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      layer_r     <= layer_nxt;
      cur_r       <= cur_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rows_r     <= rows_nxt;
    cols_r     <= cols_nxt;
    moves_r    <= moves_nxt;
    sr_r       <= sr_nxt;
    sc_r       <= sc_nxt;
    count_r    <= count_nxt;
    s1_phase_r <= s1_phase_nxt;
    s1_oob_a_r <= s1_oob_a_nxt;
    s1_oob_b_r <= s1_oob_b_nxt;
    s1_waddr_r <= s1_waddr_nxt;
    if (s1_valid_r && !s1_phase_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_path_count = count_r;

  `GEPC_ASSERT_NOW(a_s1_from_sweep, s1_valid_r, $past(state_r == ST_SWEEP), "stage without issue")
  `GEPC_ASSERT_NOW(a_write_other_bank, s1_valid_r && s1_phase_r,
                   s1_waddr_r[ADDR_W-1] == ~cur_r, "write into the layer being read")
  `GEPC_ASSERT_NOW(a_layer_range, state_r == ST_SWEEP,
                   (layer_r != '0) && (layer_r <= moves_r), "layer count out of range")
  `GEPC_ASSERT_NOW(a_count_reduced, out_valid_r, {1'b0, count_r} < MOD_P, "result not reduced")

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for grid_exit_path_count_dp: drives grid requests over the
// valid/stall input channel and checks every returned path count against a layered count
// computed here. Depends on gepc_pkg and the top-level RTL only.
module tb_top;
  import gepc_pkg::*;

  typedef struct {
    int unsigned rows;
    int unsigned cols;
    int unsigned moves;
    int unsigned srow;
    int unsigned scol;
    logic [DATA_W-1:0] count;
  } exit_request_t;

  class exit_path_ledger;
    exit_request_t pending_counts[$];
    bit [DATA_W-1:0] ways[2][MAX_ROWS][MAX_COLS];
    int errors;
    int requests;
    int outside_starts;
    int results;
    int widest_sweep;

    function longint unsigned ways_at(int layer, int r, int c, int rows, int cols);
      if (r < 0 || r >= rows || c < 0 || c >= cols) begin
        return 1;
      end
      return ways[layer][r][c];
    endfunction

    function logic [DATA_W-1:0] count_exits(int rows, int cols, int moves, int sr, int sc);
      int cur;
      longint unsigned acc;
      longint unsigned p;
      p = MOD_P;
      if (rows > MAX_ROWS) rows = MAX_ROWS;
      if (cols > MAX_COLS) cols = MAX_COLS;
      if (moves > MAX_MOVES) moves = MAX_MOVES;
      if (sr >= rows || sc >= cols) begin
        outside_starts++;
        return 1;
      end
      if (rows * cols * moves > widest_sweep) widest_sweep = rows * cols * moves;
      for (int r = 0; r < rows; r++) begin
        for (int c = 0; c < cols; c++) begin
          ways[0][r][c] = 0;
        end
      end
      cur = 0;
      for (int k = 1; k <= moves; k++) begin
        for (int r = 0; r < rows; r++) begin
          for (int c = 0; c < cols; c++) begin
            acc = ways_at(cur, r - 1, c, rows, cols) + ways_at(cur, r + 1, c, rows, cols)
                + ways_at(cur, r, c - 1, rows, cols) + ways_at(cur, r, c + 1, rows, cols);
            ways[cur ^ 1][r][c] = acc % p;
          end
        end
        cur = cur ^ 1;
      end
      return ways[cur][sr][sc];
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    function void note_request(int rows, int cols, int moves, int sr, int sc);
      exit_request_t req;
      req.rows = rows;
      req.cols = cols;
      req.moves = moves;
      req.srow = sr;
      req.scol = sc;
      req.count = count_exits(rows, cols, moves, sr, sc);
      pending_counts.push_back(req);
      requests++;
    endfunction

    task check_count(logic [DATA_W-1:0] got);
      exit_request_t req;
      results++;
      if (pending_counts.size() == 0) begin
        report_mismatch($sformatf("path count %0d arrived with no request pending", got));
      end else begin
        req = pending_counts.pop_front();
        if (got !== req.count) begin
          report_mismatch($sformatf("grid %0dx%0d moves %0d start (%0d,%0d): got %0d, want %0d",
                                    req.rows, req.cols, req.moves, req.srow, req.scol,
                                    got, req.count));
        end
      end
    endtask

    function int pending();
      return pending_counts.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [DIM_W-1:0] in_grid_rows;
  logic [DIM_W-1:0] in_grid_cols;
  logic [DIM_W-1:0] in_move_budget;
  logic [ROW_W-1:0] in_start_row;
  logic [COL_W-1:0] in_start_col;
  logic out_valid;
  logic out_stall;
  logic [DATA_W-1:0] out_path_count;

  exit_path_ledger ledger;
  bit quiet;

  grid_exit_path_count_dp u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_grid_rows   (in_grid_rows),
    .in_grid_cols   (in_grid_cols),
    .in_move_budget (in_move_budget),
    .in_start_row   (in_start_row),
    .in_start_col   (in_start_col),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_path_count (out_path_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(int rows, int cols, int moves, int sr, int sc);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_grid_rows <= rows[DIM_W-1:0];
    in_grid_cols <= cols[DIM_W-1:0];
    in_move_budget <= moves[DIM_W-1:0];
    in_start_row <= sr[ROW_W-1:0];
    in_start_col <= sc[COL_W-1:0];
    do begin
      @(posedge clk);
    end while (in_stall);
    ledger.note_request(rows, cols, moves, sr, sc);
  endtask

  task automatic send_random_request();
    int mode;
    int rows;
    int cols;
    int moves;
    int sr;
    int sc;
    mode = $urandom_range(0, 99);
    if (mode < 5) begin
      // Unconstrained sizes and starts, with a short budget to bound the sweep.
      rows = $urandom_range(0, 127);
      cols = $urandom_range(0, 127);
      moves = $urandom_range(0, 3);
      sr = $urandom_range(0, 63);
      sc = $urandom_range(0, 63);
    end else if (mode < 15) begin
      // Long thin grids reach the size limit and the full budget cheaply.
      rows = $urandom_range(1, 127);
      cols = $urandom_range(1, 3);
      moves = $urandom_range(0, 127);
      sr = $urandom_range(0, (rows > MAX_ROWS ? MAX_ROWS : rows) - 1);
      sc = $urandom_range(0, cols - 1);
      if ($urandom_range(0, 1)) begin
        {rows, cols} = {cols, rows};
        {sr, sc} = {sc, sr};
      end
    end else begin
      rows = $urandom_range(1, 8);
      cols = $urandom_range(1, 8);
      moves = $urandom_range(0, 24);
      if ($urandom_range(0, 9) == 0) begin
        sr = $urandom_range(0, 63);
        sc = $urandom_range(0, 63);
      end else begin
        sr = $urandom_range(0, rows - 1);
        sc = $urandom_range(0, cols - 1);
      end
    end
    send_request(rows, cols, moves, sr, sc);
  endtask

  initial begin
    int stall_left;
    int ready_left;
    stall_left = 0;
    ready_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (ready_left > 0) begin
        out_stall <= 1'b0;
        ready_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap();
        ready_left = $urandom_range(0, 8);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      ledger.check_count(out_path_count);
    end
  end

  initial begin
    #40_000_000;
    $display("timeout with %0d requests still pending", ledger.pending());
    $display("grid_exit_path_count_dp test failed");
    $finish;
  end

  initial begin
    ledger = new();
    quiet = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_grid_rows = '0;
    in_grid_cols = '0;
    in_move_budget = '0;
    in_start_row = '0;
    in_start_col = '0;
    out_stall = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_request(1, 1, 0, 0, 0);
    send_request(1, 1, 1, 0, 0);
    send_request(2, 2, 2, 0, 0);
    send_request(1, 3, 3, 0, 1);
    send_request(3, 3, 5, 3, 0);
    send_request(3, 3, 5, 0, 63);
    send_request(0, 5, 4, 0, 0);
    send_request(5, 0, 4, 0, 0);
    send_request(0, 0, 127, 63, 63);
    send_request(127, 2, 127, 63, 1);
    send_request(2, 127, 64, 1, 63);
    send_request(127, 127, 3, 63, 63);
    send_request(64, 64, 2, 32, 32);
    send_request(64, 1, 64, 0, 0);
    send_request(65, 3, 65, 63, 2);
    send_request(64, 1, 10, 63, 0);
    send_request(10, 10, 0, 5, 5);
    send_request(2, 3, 127, 1, 2);
    send_request(1, 1, 64, 0, 0);
    send_request(8, 8, 64, 7, 0);
    send_request(5, 7, 30, 2, 3);
    send_request(127, 127, 0, 0, 0);
    send_request(63, 63, 10, 63, 0);

    for (int i = 0; i < 100; i++) begin
      quiet = (i >= 30 && i < 50);
      send_random_request();
    end
    quiet = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (ledger.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d path counts for %0d requests, %0d of them with the start off the grid.",
             ledger.results, ledger.requests, ledger.outside_starts);
    $display("Largest sweep covered %0d cell updates; %0d mismatches seen.",
             ledger.widest_sweep, ledger.errors);
    if (ledger.errors == 0) begin
      $display("grid_exit_path_count_dp test passed");
    end else begin
      $display("grid_exit_path_count_dp test failed");
    end
    $finish;
  end
endmodule
